// ===== hw/rtl/hsv_to_rgb_converter_top_macros.svh =====
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define HSVRGB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hsvrgb_pkg.sv =====
// Types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

	// Field widths and fixed-point formats
	localparam int HUE_W    = 15;
	localparam int CH_W     = 13;
	localparam int CH_FRAC  = 12;
	localparam int HUE_FRAC = 6;
	localparam logic [CH_W-1:0] CH_ONE = CH_W'(1 << CH_FRAC);

	// One sector is 60 degrees in hue units
	localparam int SECTOR_DEG  = 60;
	localparam int SECTOR_SPAN = SECTOR_DEG << HUE_FRAC;
	localparam int NUM_SPANS   = ((1 << HUE_W) - 1) / SECTOR_SPAN;
	localparam int SPAN_IDX_W  = $clog2(NUM_SPANS + 1);
	localparam int REM_W       = $clog2(SECTOR_SPAN);

	// f = (rem << CH_FRAC) / SECTOR_SPAN by reciprocal multiply.
	// SECTOR_SPAN = 2^8 * 15, so f = floor(rem * 16 / 15) = (rem * 34953) >> 15,
	// exact for every rem below SECTOR_SPAN.
	localparam int RECIP_W  = 16;
	localparam logic [RECIP_W-1:0] FRAC_RECIP = 16'd34953;
	localparam int RECIP_SH = 15;
	localparam int FRAC_PROD_W = REM_W + RECIP_W;

	// Channel product width
	localparam int PROD_W = 2 * CH_W;

	// Hue sector, 60 degrees each; six and up wrap to the default order
	typedef enum logic [2:0] {
		SEC_R_Y  = 3'd0,
		SEC_Y_G  = 3'd1,
		SEC_G_C  = 3'd2,
		SEC_C_B  = 3'd3,
		SEC_B_M  = 3'd4,
		SEC_WRAP = 3'd5
	} sector_t;

	localparam int SECTOR_W = 3;

	// Input item
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  brightness;
	} hsv_t;

	// Result item
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Sector stage to shade stage
	typedef struct packed {
		logic            valid;
		sector_t         sector;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] frac;
	} sector_pipe_t;

	// Shade stage to channel select
	typedef struct packed {
		logic            valid;
		sector_t         sector;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] p;
		logic [CH_W-1:0] q;
		logic [CH_W-1:0] t;
	} shade_pipe_t;

endpackage

// ===== hw/rtl/hsvrgb_sector.sv =====
// Stages 1-2: input clamp, hue sector split and sector fraction.
module hsvrgb_sector
	import hsvrgb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  hsv_t         hsv,
	output sector_pipe_t pipe
);

	logic [CH_W-1:0]       sat_c;
	logic [CH_W-1:0]       val_c;
	logic [SPAN_IDX_W-1:0] span_idx;
	logic [REM_W-1:0]      rem_c;
	sector_t               sec_c;

	logic                  valid_s1;
	sector_t               sector_s1;
	logic [CH_W-1:0]       sat_s1;
	logic [CH_W-1:0]       val_s1;
	logic [REM_W-1:0]      rem_s1;

	logic [FRAC_PROD_W-1:0] frac_prod;

	logic                  valid_s2;
	sector_t               sector_s2;
	logic [CH_W-1:0]       sat_s2;
	logic [CH_W-1:0]       val_s2;
	logic [CH_W-1:0]       frac_s2;

	// Clamp channels to 1.0, find the 60-degree span and the remainder in it
	always_comb begin
		sat_c = (hsv.saturation > CH_ONE) ? CH_ONE : hsv.saturation;
		val_c = (hsv.brightness > CH_ONE) ? CH_ONE : hsv.brightness;
		span_idx = '0;
		for (int k = 1; k <= NUM_SPANS; k++) begin
			if ({1'b0, hsv.hue} >= (HUE_W + 1)'(k * SECTOR_SPAN)) begin
				span_idx = SPAN_IDX_W'(k);
			end
		end
		rem_c = REM_W'(hsv.hue - HUE_W'(span_idx * SECTOR_SPAN));
		if (span_idx < SPAN_IDX_W'(SEC_WRAP)) begin
			sec_c = sector_t'(span_idx[SECTOR_W-1:0]);
		end else begin
			sec_c = SEC_WRAP;
		end
	end

	// Fraction within the sector, 12 fractional bits
	assign frac_prod = FRAC_PROD_W'(rem_s1) * FRAC_PROD_W'(FRAC_RECIP);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		sector_s1 <= sec_c;
		sat_s1    <= sat_c;
		val_s1    <= val_c;
		rem_s1    <= rem_c;
		sector_s2 <= sector_s1;
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;
		frac_s2   <= CH_W'(frac_prod >> RECIP_SH);
	end

	assign pipe.valid  = valid_s2;
	assign pipe.sector = sector_s2;
	assign pipe.sat    = sat_s2;
	assign pipe.val    = val_s2;
	assign pipe.frac   = frac_s2;

endmodule

// ===== hw/rtl/hsvrgb_shade.sv =====
// Stages 3-4: the p, q and t channel products.
module hsvrgb_shade
	import hsvrgb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  sector_pipe_t pipe_in,
	output shade_pipe_t  pipe_out
);

	logic [PROD_W-1:0] p_prod;
	logic [PROD_W-1:0] sf_prod;
	logic [PROD_W-1:0] sinv_prod;
	logic [PROD_W-1:0] q_prod;
	logic [PROD_W-1:0] t_prod;

	logic              valid_s3;
	sector_t           sector_s3;
	logic [CH_W-1:0]   val_s3;
	logic [CH_W-1:0]   p_s3;
	logic [CH_W-1:0]   sf_s3;
	logic [CH_W-1:0]   sinv_s3;

	logic              valid_s4;
	sector_t           sector_s4;
	logic [CH_W-1:0]   val_s4;
	logic [CH_W-1:0]   p_s4;
	logic [CH_W-1:0]   q_s4;
	logic [CH_W-1:0]   t_s4;

	// Stage 3: p = v(1-s), s*f and s(1-f)
	assign p_prod    = PROD_W'(pipe_in.val) * PROD_W'(CH_ONE - pipe_in.sat);
	assign sf_prod   = PROD_W'(pipe_in.sat) * PROD_W'(pipe_in.frac);
	assign sinv_prod = PROD_W'(pipe_in.sat) * PROD_W'(CH_ONE - pipe_in.frac);

	// Stage 4: q = v(1-sf), t = v(1-s(1-f))
	assign q_prod = PROD_W'(val_s3) * PROD_W'(CH_ONE - sf_s3);
	assign t_prod = PROD_W'(val_s3) * PROD_W'(CH_ONE - sinv_s3);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= pipe_in.valid;
			valid_s4 <= valid_s3;
		end
	end

	// Payload, every product truncated to the channel format
	always_ff @(posedge clk) begin
		sector_s3 <= pipe_in.sector;
		val_s3    <= pipe_in.val;
		p_s3      <= CH_W'(p_prod >> CH_FRAC);
		sf_s3     <= CH_W'(sf_prod >> CH_FRAC);
		sinv_s3   <= CH_W'(sinv_prod >> CH_FRAC);
		sector_s4 <= sector_s3;
		val_s4    <= val_s3;
		p_s4      <= p_s3;
		q_s4      <= CH_W'(q_prod >> CH_FRAC);
		t_s4      <= CH_W'(t_prod >> CH_FRAC);
	end

	assign pipe_out.valid  = valid_s4;
	assign pipe_out.sector = sector_s4;
	assign pipe_out.val    = val_s4;
	assign pipe_out.p      = p_s4;
	assign pipe_out.q      = q_s4;
	assign pipe_out.t      = t_s4;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// HSV to RGB converter: one pixel per clock, five-stage pipeline.
//
// Takes one HSV pixel on every clock at which start is high; busy is never
// raised, so items may arrive back to back without gaps. Each item comes out
// on rgb with done high for that one cycle, in order; the receiver has no
// way to stall and must take it then. Throughput is one item per cycle, set
// by the fully pipelined multipliers; the stages are clamp and sector split,
// sector fraction, first channel products, second channel products, channel
// select. Saturation and brightness above 1.0 (4096) are clamped; zero
// saturation gives p = q = t = v, hence grey. Hues of 360 degrees and up use
// the order (v, p, q).
`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top
	import hsvrgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hsv_t hsv,
	output logic done,
	output rgb_t rgb
);

	sector_pipe_t sec_pipe;
	shade_pipe_t  shade;
	rgb_t         rgb_c;
	logic         valid_s5;
	rgb_t         rgb_s5;

	// Never stalls
	assign busy = 1'b0;

	hsvrgb_sector u_sector (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.hsv    (hsv),
		.pipe   (sec_pipe)
	);

	hsvrgb_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.pipe_in  (sec_pipe),
		.pipe_out (shade)
	);

	// Channel order by sector
	always_comb begin
		case (shade.sector)
			SEC_R_Y: rgb_c = '{red: shade.val, green: shade.t,   blue: shade.p};
			SEC_Y_G: rgb_c = '{red: shade.q,   green: shade.val, blue: shade.p};
			SEC_G_C: rgb_c = '{red: shade.p,   green: shade.val, blue: shade.t};
			SEC_C_B: rgb_c = '{red: shade.p,   green: shade.q,   blue: shade.val};
			SEC_B_M: rgb_c = '{red: shade.t,   green: shade.p,   blue: shade.val};
			default: rgb_c = '{red: shade.val, green: shade.p,   blue: shade.q};
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= shade.valid;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s5 <= rgb_c;
	end

	assign done = valid_s5;
	assign rgb  = rgb_s5;

	// Checks
	`HSVRGB_ASSERT_NEXT(a_strobe_follows, 1'b1, done == $past(shade.valid), "done lost or invented")
	`HSVRGB_ASSERT_NOW(a_out_range, done, (rgb.red <= CH_ONE) && (rgb.green <= CH_ONE) && (rgb.blue <= CH_ONE), "channel above 1.0")
	`HSVRGB_ASSERT_NEXT(a_has_value, shade.valid, (rgb.red == $past(shade.val)) || (rgb.green == $past(shade.val)) || (rgb.blue == $past(shade.val)), "no channel carries v")
	`HSVRGB_ASSERT_NEXT(a_p_is_min, shade.valid, (rgb.red >= $past(shade.p)) && (rgb.green >= $past(shade.p)) && (rgb.blue >= $past(shade.p)), "channel below p")

endmodule
